/* hw/rtl/crf_pkg.sv */
// shared types, constants and byte-scan functions for the changed region finder
`timescale 1ns / 1ps

package crf_pkg;

   // frame geometry
   localparam int MAX_WORDS   = 4096;
   localparam int WORD_IDX_W  = $clog2(MAX_WORDS);
   localparam int START_W     = 15;
   localparam int END_W       = 16;
   localparam int GAP_W       = 4;
   localparam int BYTE_IDX_W  = 3;
   localparam logic [GAP_W-1:0] GAP_RESET = 4'd5;

   // result queue geometry
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // one queue entry: the one or two regions caused by a single request
   typedef struct packed {
      logic               two;
      logic [START_W-1:0] start0;
      logic [END_W-1:0]   end0;
      logic [START_W-1:0] start1;
      logic [END_W-1:0]   end1;
   } crf_entry_type;

   // write side of the result queue
   typedef struct packed {
      logic          valid;
      crf_entry_type entry;
   } crf_push_type;

   // unchanged low-address bytes of a difference word
   function automatic logic [BYTE_IDX_W-1:0] low_same(input logic [63:0] d);
      logic [BYTE_IDX_W-1:0] n;
      logic                  hit;
      n   = '0;
      hit = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (!hit && (d[8*i +: 8] != 8'h00)) begin
            n   = BYTE_IDX_W'(i);
            hit = 1'b1;
         end
      end
      return n;
   endfunction

   // unchanged high-address bytes of a difference word
   function automatic logic [BYTE_IDX_W-1:0] high_same(input logic [63:0] d);
      logic [BYTE_IDX_W-1:0] n;
      logic                  hit;
      n   = '0;
      hit = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (!hit && (d[8*(7-i) +: 8] != 8'h00)) begin
            n   = BYTE_IDX_W'(i);
            hit = 1'b1;
         end
      end
      return n;
   endfunction

endpackage

/* hw/rtl/changed_region_finder.sv */
// top level of the changed region finder: front end, result queue, output sequencer
// a request's regions enter the result queue on accept and are offered on rsp from its head
// one request per cycle while the result queue is not full; a request that closes two regions
//    takes two rsp transfers on the single output port draining a four-entry result queue
// req_tready drops only when the result queue is full
// reset (synchronous) empties the queue, closes any region, zeroes the word index, gap 5
`timescale 1ns / 1ps

module changed_region_finder (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [crf_pkg::GAP_W-1:0] csr_wr_data,  // merge_gap
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [127:0]              req_tdata,    // old_word [63:0], new_word [127:64]
   input  logic                      req_tlast,    // last_word
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [31:0]               rsp_tdata,    // region_start [14:0], region_end [30:15]
   output logic                      rsp_tlast     // last_of_item
);

   crf_pkg::crf_push_type  push;
   crf_pkg::crf_entry_type head;
   logic                   empty;
   logic                   full;
   logic                   pop;
   logic                   req_accept;

   assign req_tready = !full;
   assign req_accept = req_tvalid && req_tready;

   crf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (req_accept),
      .old_word    (req_tdata[63:0]),
      .new_word    (req_tdata[127:64]),
      .last_word   (req_tlast),
      .push        (push)
   );

   crf_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .empty (empty),
      .full  (full)
   );

   crf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* hw/rtl/crf_front.sv */
// front end: accepts word pairs, tracks the open region and builds result entries
`timescale 1ns / 1ps

module crf_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [crf_pkg::GAP_W-1:0] csr_wr_data,
   input  logic                      accept,
   input  logic [63:0]               old_word,
   input  logic [63:0]               new_word,
   input  logic                      last_word,
   output crf_pkg::crf_push_type     push
);

   logic [crf_pkg::GAP_W-1:0]      merge_gap_ff, merge_gap_in;
   logic                           region_open_ff, region_open_in;
   logic [crf_pkg::START_W-1:0]    open_start_ff, open_start_in;
   logic [crf_pkg::BYTE_IDX_W-1:0] trailing_ff, trailing_in;
   logic [crf_pkg::WORD_IDX_W-1:0] word_index_ff, word_index_in;

   logic [63:0]                    diff;
   logic                           changed;
   logic                           final_word;
   logic [crf_pkg::BYTE_IDX_W-1:0] lead;
   logic [crf_pkg::BYTE_IDX_W-1:0] trail_new;
   logic [crf_pkg::START_W-1:0]    base;
   logic [crf_pkg::END_W-1:0]      base_ext;
   logic                           gap_split;
   logic                           close_a;
   logic                           open_mid;
   logic [crf_pkg::START_W-1:0]    start_mid;
   logic [crf_pkg::BYTE_IDX_W-1:0] trail_mid;
   logic                           close_b;
   logic [crf_pkg::END_W-1:0]      end_a;
   logic [crf_pkg::END_W-1:0]      end_b;

   // classify the word pair
   assign diff       = old_word ^ new_word;
   assign changed    = |diff;
   assign lead       = crf_pkg::low_same(diff);
   assign trail_new  = crf_pkg::high_same(diff);
   assign final_word = last_word ||
                       (word_index_ff == crf_pkg::WORD_IDX_W'(crf_pkg::MAX_WORDS - 1));
   assign base       = crf_pkg::START_W'({word_index_ff, 3'b000});
   assign base_ext   = crf_pkg::END_W'(base);

   // gap between the last changed word and this one
   assign gap_split = ({1'b0, trailing_ff} + {1'b0, lead}) >= merge_gap_ff;

   // first possible region: closed by an unchanged word or by a wide gap
   assign close_a = region_open_ff && (!changed || gap_split);
   assign end_a   = base_ext - crf_pkg::END_W'(trailing_ff);

   // region state after this word, before the final-word close
   assign open_mid  = changed;
   assign start_mid = (changed && (!region_open_ff || close_a)) ?
                      (base + crf_pkg::START_W'(lead)) : open_start_ff;
   assign trail_mid = changed ? trail_new : trailing_ff;

   // second possible region: closed at the end of the frame
   assign close_b = final_word && open_mid;
   assign end_b   = base_ext + crf_pkg::END_W'(8) - crf_pkg::END_W'(trail_mid);

   // entry for the result queue
   always_comb begin
      push.valid        = accept && (close_a || close_b);
      push.entry.two    = close_a && close_b;
      push.entry.start0 = close_a ? open_start_ff : start_mid;
      push.entry.end0   = close_a ? end_a : end_b;
      push.entry.start1 = start_mid;
      push.entry.end1   = end_b;
   end

   // next state
   always_comb begin
      merge_gap_in   = csr_wr_en ? csr_wr_data : merge_gap_ff;
      region_open_in = region_open_ff;
      open_start_in  = open_start_ff;
      trailing_in    = trailing_ff;
      word_index_in  = word_index_ff;
      if (accept) begin
         region_open_in = open_mid && !final_word;
         open_start_in  = start_mid;
         trailing_in    = trail_mid;
         word_index_in  = final_word ? '0 : word_index_ff + 1'b1;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         merge_gap_ff   <= crf_pkg::GAP_RESET;
         region_open_ff <= 1'b0;
         open_start_ff  <= '0;
         trailing_ff    <= '0;
         word_index_ff  <= '0;
      end else begin
         merge_gap_ff   <= merge_gap_in;
         region_open_ff <= region_open_in;
         open_start_ff  <= open_start_in;
         trailing_ff    <= trailing_in;
         word_index_ff  <= word_index_in;
      end
   end

endmodule

/* hw/rtl/crf_queue.sv */
// short result queue between the front end and the output sequencer
`timescale 1ns / 1ps

module crf_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  crf_pkg::crf_push_type  push,
   input  logic                   pop,
   output crf_pkg::crf_entry_type head,
   output logic                   empty,
   output logic                   full
);

   crf_pkg::crf_entry_type         slots_ff [crf_pkg::QUEUE_DEPTH];
   logic [crf_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [crf_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [crf_pkg::QCNT_W-1:0]     count_ff, count_in;
   logic                           do_push;
   logic                           do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == crf_pkg::QCNT_W'(crf_pkg::QUEUE_DEPTH));
   assign do_push = push.valid && !full;
   assign do_pop  = pop && !empty;
   assign head    = slots_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push.entry;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push.valid)
      else $error("request result pushed into a full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= crf_pkg::QCNT_W'(crf_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not grow on push");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with mismatched pointers");
`endif

endmodule

/* hw/rtl/crf_back.sv */
// back end: plays out the one or two regions of each queue entry
`timescale 1ns / 1ps

module crf_back (
   input  logic                   clock,
   input  logic                   reset,
   input  crf_pkg::crf_entry_type head,
   input  logic                   empty,
   output logic                   pop,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   output logic [31:0]            rsp_tdata,
   output logic                   rsp_tlast
);

   logic sub_ff, sub_in;
   logic take;

   assign rsp_tvalid = !empty;
   assign take       = rsp_tvalid && rsp_tready;
   assign rsp_tlast  = sub_ff || !head.two;
   assign pop        = take && rsp_tlast;

   // pick the region of the entry now shown
   always_comb begin
      if (sub_ff) begin
         rsp_tdata = {1'b0, head.end1, head.start1};
      end else begin
         rsp_tdata = {1'b0, head.end0, head.start0};
      end
   end

   // second region of a two-region entry follows the first
   always_comb begin
      sub_in = sub_ff;
      if (take) begin
         sub_in = !rsp_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= 1'b0;
      end else begin
         sub_ff <= sub_in;
      end
   end

endmodule

/* test/changed_region_checker.sv */
// region predictor and result checker for the changed region finder
`timescale 1ns / 1ps

module changed_region_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [crf_pkg::GAP_W-1:0] csr_wr_data,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [127:0]              req_tdata,
   input  logic                      req_tlast,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [31:0]               rsp_tdata,
   input  logic                      rsp_tlast,
   output int                        mismatches,
   output int                        pending,
   output int                        regions_checked
);

   // one predicted region, as it should appear on rsp
   typedef struct packed {
      logic [crf_pkg::START_W-1:0] first_byte;
      logic [crf_pkg::END_W-1:0]   past_byte;
      logic                        final_flag;
   } region_bounds_type;

   // shadow of the block state
   logic [crf_pkg::GAP_W-1:0]      gap_setting = crf_pkg::GAP_RESET;
   logic                           open_now    = 1'b0;
   logic [crf_pkg::START_W-1:0]    open_first  = '0;
   logic [2:0]                     tail_same   = '0;
   logic [crf_pkg::WORD_IDX_W-1:0] word_pos    = '0;

   region_bounds_type regions_due[$];
   int bad       = 0;
   int seen      = 0;
   int due_count = 0;

   assign mismatches      = bad;
   assign pending         = due_count;
   assign regions_checked = seen;

   // unchanged bytes counted up from byte 0
   function automatic int quiet_low(input logic [63:0] d);
      int k;
      k = 0;
      while (k < 8 && d[8*k +: 8] == 8'h00) k++;
      return k;
   endfunction

   // unchanged bytes counted down from byte 7
   function automatic int quiet_high(input logic [63:0] d);
      int k;
      k = 0;
      while (k < 8 && d[8*(7-k) +: 8] == 8'h00) k++;
      return k;
   endfunction

   function automatic region_bounds_type bounds(input int first, input int past);
      region_bounds_type r;
      r.first_byte = crf_pkg::START_W'(first);
      r.past_byte  = crf_pkg::END_W'(past);
      r.final_flag = 1'b0;
      return r;
   endfunction

   // advance the shadow state by one request and queue the regions it closes
   task automatic trace_word(input logic [63:0] old_w, input logic [63:0] new_w,
                             input logic last_w);
      logic [63:0]       diff;
      logic              ends_frame;
      int                base;
      int                lead;
      region_bounds_type found[$];
      diff       = old_w ^ new_w;
      ends_frame = last_w ||
                   (word_pos == crf_pkg::WORD_IDX_W'(crf_pkg::MAX_WORDS - 1));
      base       = int'(word_pos) * 8;
      if (diff == '0) begin
         // unchanged word closes the open region
         if (open_now) begin
            found.push_back(bounds(int'(open_first), base - int'(tail_same)));
            open_now = 1'b0;
         end
      end else begin
         lead = quiet_low(diff);
         // unchanged run too long to bridge: split
         if (open_now && (int'(tail_same) + lead >= int'(gap_setting))) begin
            found.push_back(bounds(int'(open_first), base - int'(tail_same)));
            open_now = 1'b0;
         end
         if (!open_now) begin
            open_now   = 1'b1;
            open_first = crf_pkg::START_W'(base + lead);
         end
         tail_same = 3'(quiet_high(diff));
      end
      // end of frame, by flag or by running out of word index
      if (ends_frame) begin
         if (open_now) begin
            found.push_back(bounds(int'(open_first), base + 8 - int'(tail_same)));
            open_now = 1'b0;
         end
         word_pos = '0;
      end else begin
         word_pos = word_pos + 1'b1;
      end
      if (found.size() > 0) found[found.size()-1].final_flag = 1'b1;
      foreach (found[k]) regions_due.push_back(found[k]);
   endtask

   // compare one returned region against the oldest prediction
   task automatic check_region();
      region_bounds_type           want;
      logic [crf_pkg::START_W-1:0] got_first;
      logic [crf_pkg::END_W-1:0]   got_past;
      got_first = rsp_tdata[crf_pkg::START_W-1:0];
      got_past  = rsp_tdata[crf_pkg::START_W +: crf_pkg::END_W];
      if (regions_due.size() == 0) begin
         $display("%0t: expected no region, actual [%0d,%0d) last %0b",
                  $time, got_first, got_past, rsp_tlast);
         bad++;
      end else begin
         want = regions_due.pop_front();
         seen++;
         if (got_first !== want.first_byte) begin
            $display("%0t: region start expected %0d, actual %0d",
                     $time, want.first_byte, got_first);
            bad++;
         end
         if (got_past !== want.past_byte) begin
            $display("%0t: region end expected %0d, actual %0d",
                     $time, want.past_byte, got_past);
            bad++;
         end
         if (rsp_tlast !== want.final_flag) begin
            $display("%0t: last of request expected %0b, actual %0b",
                     $time, want.final_flag, rsp_tlast);
            bad++;
         end
      end
   endtask

   // sample every handshake at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         gap_setting = crf_pkg::GAP_RESET;
         open_now    = 1'b0;
         open_first  = '0;
         tail_same   = '0;
         word_pos    = '0;
         regions_due.delete();
      end else begin
         if (csr_wr_en) gap_setting = csr_wr_data;
         if (req_tvalid && req_tready) begin
            trace_word(req_tdata[63:0], req_tdata[127:64], req_tlast);
         end
         if (rsp_tvalid && rsp_tready) check_region();
      end
      due_count = regions_due.size();
   end

endmodule

/* test/testbench.sv */
// stimulus, pacing and verdict for the changed region finder
`timescale 1ns / 1ps

module testbench;

   localparam int HOLD_CYCLES = 120;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 135;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      csr_wr_en   = 1'b0;
   logic [crf_pkg::GAP_W-1:0] csr_wr_data = crf_pkg::GAP_RESET;
   logic                      req_tvalid  = 1'b0;
   logic                      req_tready;
   logic [127:0]              req_tdata   = '0;
   logic                      req_tlast   = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready  = 1'b0;
   logic [31:0]               rsp_tdata;
   logic                      rsp_tlast;

   int mismatches;
   int pending;
   int regions_checked;
   int requests_sent = 0;
   int frames_sent   = 0;
   int gap_writes    = 0;
   bit hold_long     = 1'b0;
   bit rx_steady     = 1'b0;
   bit tx_steady     = 1'b0;

   changed_region_finder DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   changed_region_checker region_check (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .mismatches      (mismatches),
      .pending         (pending),
      .regions_checked (regions_checked)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // idle length: mostly none or short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   // byte difference pattern between old and new word
   function automatic logic [63:0] rand_diff();
      logic [63:0] d;
      int          mode;
      int          b;
      int          k;
      d    = '0;
      mode = $urandom_range(0, 11);
      if (mode < 3) begin
         d = '0;
      end else if (mode == 3) begin
         for (b = 0; b < 8; b++) d[8*b +: 8] = 8'($urandom_range(1, 255));
      end else if (mode == 4) begin
         b = $urandom_range(0, 7);
         d[8*b +: 8] = 8'($urandom_range(1, 255));
      end else if (mode == 5) begin
         // changes confined to the low end
         k = $urandom_range(1, 8);
         for (b = 0; b < k; b++) d[8*b +: 8] = 8'($urandom_range(1, 255));
      end else if (mode == 6) begin
         // changes confined to the high end
         k = $urandom_range(1, 8);
         for (b = 8 - k; b < 8; b++) d[8*b +: 8] = 8'($urandom_range(1, 255));
      end else if (mode == 7) begin
         d = {$urandom, $urandom};
      end else begin
         for (b = 0; b < 8; b++) begin
            if ($urandom_range(0, 1) == 1) d[8*b +: 8] = 8'($urandom_range(1, 255));
         end
      end
      return d;
   endfunction

   // offer one request and wait for it to be taken
   task automatic push_word(input logic [63:0] old_w, input logic [63:0] new_w,
                            input logic last_w);
      int g;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {new_w, old_w};
      req_tlast  <= last_w;
      do @(posedge clock); while (!req_tready);
      requests_sent++;
      g = tx_steady ? 0 : pick_gap();
      if (g > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (g - 1) @(negedge clock);
      end
   endtask

   // random frame of the given length
   task automatic send_frame(input int words);
      logic [63:0] w;
      int          i;
      for (i = 0; i < words; i++) begin
         w = {$urandom, $urandom};
         push_word(w, w ^ rand_diff(), i == words - 1);
      end
      frames_sent++;
   endtask

   // stop offering and wait until every predicted region has come back
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_gap(input logic [crf_pkg::GAP_W-1:0] g);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= g;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      gap_writes++;
   endtask

   // rsp side pacing, with one long hold on demand
   initial begin : rsp_pacing
      int g;
      @(negedge clock);
      forever begin
         if (hold_long) begin
            hold_long = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (rx_steady) begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clock);
            g = pick_gap();
            if (g > 0) begin
               rsp_tready <= 1'b0;
               repeat (g) @(negedge clock);
            end
         end
      end
   end

   // run limit
   initial begin : watchdog
      #20_000_000;
      $display("%0t: run did not complete in time", $time);
      $display("Mismatches found");
      $finish;
   end

   // request stimulus
   initial begin : stimulus
      int          phase;
      int          sent_mark;
      int          i;
      bit          paused;
      logic [63:0] w;
      paused = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset gap: full change, no change, merge then close
      push_word('1, '0, 1'b1);
      push_word('1, '1, 1'b1);
      push_word('0, 64'hFF00_0000_0000_0000, 1'b0);
      push_word('0, 64'h0000_0000_0000_00FF, 1'b0);
      push_word(64'h1234_5678_9ABC_DEF0, 64'h1234_5678_9ABC_DEF0, 1'b0);
      push_word('0, 64'h0000_0000_FF00_0000, 1'b1);
      // split region and final word region from the same request
      push_word('0, 64'h0000_0000_0000_0001, 1'b0);
      push_word('0, 64'h8000_0000_0000_0000, 1'b1);
      settle();

      // gap of zero: every changed word after a changed word splits
      set_gap('0);
      push_word('0, '1, 1'b0);
      push_word('0, '1, 1'b0);
      push_word('1, '0, 1'b1);
      settle();

      // widest gap bridges the longest possible unchanged run
      set_gap('1);
      push_word('0, 64'h0000_0000_0000_0001, 1'b0);
      push_word('0, 64'h8000_0000_0000_0000, 1'b0);
      push_word('1, '1, 1'b1);
      settle();

      // frame too long: the last index ends the frame without last_word
      set_gap(crf_pkg::GAP_RESET);
      tx_steady = 1'b1;
      for (i = 0; i < crf_pkg::MAX_WORDS; i++) begin
         w = {$urandom, $urandom};
         if (i == crf_pkg::MAX_WORDS - 1) push_word(w, w ^ 64'hFF00_0000_0000_0000, 1'b0);
         else if (i % 97 == 3) push_word(w, w ^ rand_diff(), 1'b0);
         else push_word(w, w, 1'b0);
      end
      tx_steady = 1'b0;
      // word index starts again at zero
      push_word('0, 64'h0000_0000_0000_00FF, 1'b0);
      push_word('0, '0, 1'b0);
      push_word('0, 64'h00FF_0000_0000_0000, 1'b1);
      frames_sent += 8;

      // random frames over a range of gap settings and pacing
      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            0: set_gap('1);
            1: set_gap('0);
            2: set_gap(crf_pkg::GAP_W'(1));
            3: set_gap(crf_pkg::GAP_W'(14));
            default: set_gap(crf_pkg::GAP_W'($urandom_range(0, 15)));
         endcase
         rx_steady = (phase == 1) || (phase == 6);
         tx_steady = (phase == 2) || (phase == 3) || (phase == 6);
         // long output stall while requests keep coming
         if (phase == 3) hold_long = 1'b1;
         sent_mark = requests_sent;
         while (requests_sent - sent_mark < PHASE_ITEMS) begin
            // sender waits for the block to drain mid-phase
            if (phase == 5 && !paused && requests_sent - sent_mark >= PHASE_ITEMS / 2) begin
               settle();
               paused = 1'b1;
            end
            send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(13, 48)
                                                    : $urandom_range(1, 12));
         end
      end
      rx_steady = 1'b0;
      tx_steady = 1'b0;
      settle();
      repeat (10) @(posedge clock);

      $display("%0d frames in %0d requests, %0d regions compared",
               frames_sent, requests_sent, regions_checked);
      $display("%0d merge gap writes from 0 to 15, one %0d-word frame, one long rsp stall",
               gap_writes, crf_pkg::MAX_WORDS);
      if (mismatches == 0 && pending == 0) begin
         $display("No mismatches found");
      end else begin
         if (pending != 0) $display("%0t: %0d predicted regions never came", $time, pending);
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
